// File: src/assert_macros.svh
// assertion macros used by the frwl_chk checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/frwl_pkg.sv
// ----------------------------------------------------------------------------
// frwl_pkg
// types and codes of the fair fifo reader-writer lock
// ----------------------------------------------------------------------------
`default_nettype none

package frwl_pkg;

    typedef enum logic [1:0] {
        OP_ACQ_RD = 2'd0,
        OP_ACQ_WR = 2'd1,
        OP_REL_RD = 2'd2,
        OP_REL_WR = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_HOLDER = 2'd2,
        ST_NONE      = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ACK   = 1'b0,
        KIND_GRANT = 1'b1
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_STEP
    } t_state;

    localparam int          GRANTEE_W  = 8;
    localparam int          READER_W   = 9;
    localparam logic [8:0]  READER_MAX = 9'd511;

    typedef struct packed {
        t_kind                 kind;
        logic [GRANTEE_W-1:0]  grantee;
        logic                  is_writer;
        t_status               status;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit;
        logic grant;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic grant_ok;
        logic slot_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: src/frwl_if.sv
// ----------------------------------------------------------------------------
// frwl_ev_if / frwl_res_if
// valid-ready channels for lock events and for results
// ----------------------------------------------------------------------------
`default_nettype none

interface frwl_ev_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] requester;

    modport source (output valid, output opcode, output requester, input ready);
    modport sink   (input valid, input opcode, input requester, output ready);
endinterface

interface frwl_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] grantee;
    logic       grant_is_writer;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output kind, output grantee, output grant_is_writer,
                    output status, output last, input ready);
    modport sink   (input valid, input kind, input grantee, input grant_is_writer,
                    input status, input last, output ready);
endinterface

`default_nettype wire

// File: src/frwl_ctrl.sv
// ----------------------------------------------------------------------------
// frwl_ctrl
// sequences event acceptance, the acknowledgement and the grant pass
// ----------------------------------------------------------------------------
`default_nettype none

module frwl_ctrl
    import frwl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_ev_valid,
    output logic          o_ev_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ev_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.grant  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no transfer is taken while reset is held
                o_ev_ready   = i_rst_n;
                o_cmd.accept = i_ev_valid && i_rst_n;
                if (i_ev_valid && i_rst_n) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                // pending result leaves once the output register can take it
                if (i_stat.slot_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.grant = i_stat.grant_ok;
                    if (!i_stat.grant_ok) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/frwl_dp.sv
// ----------------------------------------------------------------------------
// frwl_dp
// wait queue, lock counts, pending result and output register
// ----------------------------------------------------------------------------
`default_nettype none

module frwl_dp
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int REQUESTER_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_stat        o_stat,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_requester,
    input  wire logic       i_out_ready,
    output logic            o_out_valid,
    output t_result         o_out,
    output logic            o_out_last
);

    localparam int IdxW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int SumW = CntW + 1;
    localparam int EntW = REQUESTER_BITS + 1;

    logic [EntW-1:0]     r_queue [QUEUE_DEPTH];
    logic [EntW-1:0]     r_head_ent;
    logic [IdxW-1:0]     r_head, n_head;
    logic [CntW-1:0]     r_count, n_count;
    logic [READER_W-1:0] r_readers, n_readers;
    logic                r_writer, n_writer;
    t_result             r_pend, n_pend;
    t_result             r_out;
    logic                r_out_last;
    logic                r_out_valid, n_out_valid;

    t_opcode             op;
    logic                op_wr;
    logic [REQUESTER_BITS-1:0] req_id;
    logic [SumW-1:0]     tail_sum;
    logic [IdxW-1:0]     tail;
    logic                wr_en;
    logic [EntW-1:0]     wr_data;
    logic                head_is_wr;
    logic                grant_ok;
    t_status             ack_status;

    assign op       = t_opcode'(i_opcode);
    assign op_wr    = (op == OP_ACQ_WR) || (op == OP_REL_WR);
    assign req_id   = REQUESTER_BITS'(i_requester);
    assign wr_data  = {op_wr, req_id};

    always_comb begin
        tail_sum = SumW'(r_head) + SumW'(r_count);
        if (tail_sum >= SumW'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SumW'(QUEUE_DEPTH);
        end
        tail = tail_sum[IdxW-1:0];
    end

    assign head_is_wr = r_head_ent[EntW-1];
    assign grant_ok   = (r_count != '0) && !r_writer &&
                        (head_is_wr ? (r_readers == '0) : (r_readers != READER_MAX));

    assign o_stat.grant_ok  = grant_ok;
    assign o_stat.slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_readers   = r_readers;
        n_writer    = r_writer;
        n_pend      = r_pend;
        wr_en       = 1'b0;
        ack_status  = ST_OK;

        if (i_cmd.accept) begin
            unique case (op) inside
                OP_ACQ_RD, OP_ACQ_WR: begin
                    if (r_count == CntW'(QUEUE_DEPTH)) begin
                        ack_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_REL_RD: begin
                    if (r_readers == '0) begin
                        ack_status = ST_NO_HOLDER;
                    end else begin
                        n_readers = r_readers - 1'b1;
                    end
                end
                OP_REL_WR: begin
                    if (!r_writer) begin
                        ack_status = ST_NO_HOLDER;
                    end else begin
                        n_writer = 1'b0;
                    end
                end
                default: ack_status = ST_OK;
            endcase
            n_pend.kind      = KIND_ACK;
            n_pend.grantee   = GRANTEE_W'(req_id);
            n_pend.is_writer = op_wr;
            n_pend.status    = ack_status;
        end

        if (i_cmd.grant) begin
            n_head  = (r_head == IdxW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
            if (head_is_wr) begin
                n_writer = 1'b1;
            end else begin
                n_readers = r_readers + 1'b1;
            end
            n_pend.kind      = KIND_GRANT;
            n_pend.grantee   = GRANTEE_W'(r_head_ent[REQUESTER_BITS-1:0]);
            n_pend.is_writer = head_is_wr;
            n_pend.status    = ST_OK;
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_readers   <= '0;
            r_writer    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_readers   <= n_readers;
            r_writer    <= n_writer;
            r_out_valid <= n_out_valid;
        end
    end

    // queue memory: write at the tail, registered read that follows the head
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_queue[tail] <= wr_data;
        end
        if (wr_en && (tail == n_head)) begin
            r_head_ent <= wr_data;
        end else begin
            r_head_ent <= r_queue[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (i_cmd.emit) begin
            r_out      <= r_pend;
            r_out_last <= !grant_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// File: src/fifo_fair_reader_writer_lock_top.sv
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_lock_top
// fair fifo reader-writer lock arbiter
// ----------------------------------------------------------------------------
// Each lock event is accepted in the idle state, which loads its
// acknowledgement into a pending register; one grant per cycle follows while
// the queue head may take the lock and the result side does not stall. The
// controller steps one result per cycle through the pending register while
// the output register is free, and the queue memory's registered read port
// always holds the current head. A new event is taken as soon as the previous
// one has handed its last result to the output register. The queue needs no
// clearing after reset.
`default_nettype none

module fifo_fair_reader_writer_lock_top
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int REQUESTER_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    frwl_ev_if.sink     i_ev,
    frwl_res_if.source  o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_result  res;
    logic     res_valid;
    logic     res_last;
    logic     ev_ready;

    frwl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (i_ev.valid),
        .o_ev_ready (ev_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    frwl_dp #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .REQUESTER_BITS (REQUESTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_opcode    (i_ev.opcode),
        .i_requester (i_ev.requester),
        .i_out_ready (o_res.ready),
        .o_out_valid (res_valid),
        .o_out       (res),
        .o_out_last  (res_last)
    );

    assign i_ev.ready            = ev_ready;
    assign o_res.valid           = res_valid;
    assign o_res.kind            = res.kind;
    assign o_res.grantee         = res.grantee;
    assign o_res.grant_is_writer = res.is_writer;
    assign o_res.status          = res.status;
    assign o_res.last            = res_last;

endmodule

`default_nettype wire

// File: src/frwl_chk.sv
// ----------------------------------------------------------------------------
// frwl_chk
// port-level checks on the result sequence of the lock arbiter
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module frwl_chk
    import frwl_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_res_valid,
    input wire logic       i_res_ready,
    input wire logic       i_res_kind,
    input wire logic [1:0] i_res_status,
    input wire logic       i_res_last
);

    logic r_expect_ack;
    logic res_xfer;

    assign res_xfer = i_res_valid && i_res_ready;

    // the first result after a last one opens a new event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_ack <= 1'b1;
        end else if (res_xfer) begin
            r_expect_ack <= i_res_last;
        end
    end

    `ASSERT_ALWAYS(a_ack_first, i_clk, i_rst_n, !(res_xfer && r_expect_ack) || (i_res_kind == KIND_ACK), "event results do not open with an acknowledgement")
    `ASSERT_ALWAYS(a_grant_after, i_clk, i_rst_n, !(res_xfer && !r_expect_ack) || (i_res_kind == KIND_GRANT), "acknowledgement inside a grant run")
    `ASSERT_ALWAYS(a_grant_ok, i_clk, i_rst_n, !(i_res_valid && (i_res_kind == KIND_GRANT)) || (i_res_status == ST_OK), "grant with a status other than ok")
    `ASSERT_ALWAYS(a_no_none, i_clk, i_rst_n, !i_res_valid || (i_res_status != ST_NONE), "status none shown")
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_kind) && $stable(i_res_last), "stalled result dropped or changed")

endmodule

bind fifo_fair_reader_writer_lock_top frwl_chk u_frwl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.kind),
    .i_res_status (o_res.status),
    .i_res_last   (o_res.last)
);

`default_nettype wire

// File: bench/frwl_lock_checker.sv
// ----------------------------------------------------------------------------
// frwl_lock_checker
// watches the event and result channels of the reader-writer lock, keeps its
// own copy of the wait queue and lock holders, and compares every result
// transfer field by field with the oldest outstanding prediction
// ----------------------------------------------------------------------------

module frwl_lock_checker
    import frwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    frwl_ev_if        i_ev,
    frwl_res_if       i_res,
    output int        o_err_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_kind      kind;
        logic [7:0] grantee;
        logic       is_writer;
        t_status    status;
        logic       last;
    } t_lock_out;

    t_lock_out             outstanding_q[$];
    logic [8:0]            wait_slot [QUEUE_DEPTH];
    int                    q_head;
    int                    q_count;
    logic [READER_W-1:0]   readers;
    logic                  writer_held;
    int                    err_total = 0;
    int                    result_no = 0;
    int                    pending_cnt = 0;

    assign o_err_count = err_total;
    assign o_pending   = pending_cnt;

    task automatic report_mismatch(string msg);
        err_total++;
        $display("%0t ns: result %0d: %s", $time, result_no, msg);
    endtask

    // apply one lock event, then grant from the queue head while allowed
    function automatic void predict_event(t_opcode op, logic [7:0] id);
        t_lock_out  cur;
        logic [8:0] head_entry;
        bit         blocked;
        t_status    st;
        st = ST_OK;
        case (op)
            OP_ACQ_RD, OP_ACQ_WR: begin
                if (q_count >= QUEUE_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    wait_slot[(q_head + q_count) % QUEUE_DEPTH] = {op == OP_ACQ_WR, id};
                    q_count++;
                end
            end
            OP_REL_RD: begin
                if (readers == 0) st = ST_NO_HOLDER;
                else readers--;
            end
            default: begin
                if (!writer_held) st = ST_NO_HOLDER;
                else writer_held = 1'b0;
            end
        endcase
        cur = '{KIND_ACK, id, (op == OP_ACQ_WR) || (op == OP_REL_WR), st, 1'b0};
        blocked = 1'b0;
        while (q_count > 0 && !blocked) begin
            head_entry = wait_slot[q_head];
            if (head_entry[8]) blocked = writer_held || (readers != 0);
            else blocked = writer_held || (readers == READER_MAX);
            if (!blocked) begin
                if (head_entry[8]) writer_held = 1'b1;
                else readers++;
                outstanding_q.push_back(cur);
                cur = '{KIND_GRANT, head_entry[7:0], head_entry[8], ST_OK, 1'b0};
                q_head = (q_head + 1) % QUEUE_DEPTH;
                q_count--;
            end
        end
        cur.last = 1'b1;
        outstanding_q.push_back(cur);
    endfunction

    task automatic check_result();
        t_lock_out want;
        if (outstanding_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, grantee %0h", i_res.grantee));
        end else begin
            want = outstanding_q.pop_front();
            if (i_res.kind !== want.kind)
                report_mismatch($sformatf("kind expected %0d got %0d",
                                          want.kind, i_res.kind));
            if (i_res.grantee !== want.grantee)
                report_mismatch($sformatf("grantee expected %0h got %0h",
                                          want.grantee, i_res.grantee));
            if (i_res.grant_is_writer !== want.is_writer)
                report_mismatch($sformatf("grant_is_writer expected %0d got %0d",
                                          want.is_writer, i_res.grant_is_writer));
            if (i_res.status !== want.status)
                report_mismatch($sformatf("status expected %0d got %0d",
                                          want.status, i_res.status));
            if (i_res.last !== want.last)
                report_mismatch($sformatf("last expected %0d got %0d",
                                          want.last, i_res.last));
        end
        result_no++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (wait_slot[k]) wait_slot[k] = '0;
            q_head      = 0;
            q_count     = 0;
            readers     = '0;
            writer_held = 1'b0;
            outstanding_q.delete();
            pending_cnt <= 0;
        end else begin
            // a result can never belong to the event taken at the same edge
            if (i_res.valid && i_res.ready) check_result();
            if (i_ev.valid && i_ev.ready) predict_event(t_opcode'(i_ev.opcode), i_ev.requester);
            pending_cnt <= outstanding_q.size();
        end
    end

endmodule

// File: bench/tb_fifo_fair_reader_writer_lock_top.sv
// ----------------------------------------------------------------------------
// tb_fifo_fair_reader_writer_lock_top
// drives lock events into the reader-writer lock with random gaps and result
// back-pressure: a directed opening and random bursts of acquires and
// releases; the checker gives the verdict
// ----------------------------------------------------------------------------

module tb_fifo_fair_reader_writer_lock_top;
    timeunit 1ns;
    timeprecision 1ps;
    import frwl_pkg::*;

    localparam int DEPTH      = 16;
    localparam int RAND_ITEMS = 375;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;

    int   tx_left = 0;
    bit   tx_eager = 1'b0;
    int   rx_left = 0;
    bit   rx_eager = 1'b0;

    frwl_ev_if  ev_ch();
    frwl_res_if res_ch();

    fifo_fair_reader_writer_lock_top #(
        .QUEUE_DEPTH    (DEPTH),
        .REQUESTER_BITS (8)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_ev    (ev_ch),
        .o_res   (res_ch)
    );

    frwl_lock_checker #(
        .QUEUE_DEPTH (DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_ev        (ev_ch),
        .i_res       (res_ch),
        .o_err_count (errors),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] rand_id();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_opcode rand_acquire();
        return ($urandom_range(0, 2) == 0) ? OP_ACQ_WR : OP_ACQ_RD;
    endfunction

    function automatic t_opcode rand_release();
        return ($urandom_range(0, 2) == 0) ? OP_REL_WR : OP_REL_RD;
    endfunction

    task automatic send_event(t_opcode op, logic [7:0] id);
        int gap;
        // alternate between stretches of random gaps and back-to-back transfers
        if (tx_left == 0) begin
            tx_eager = ($urandom_range(0, 3) == 0);
            tx_left  = $urandom_range(10, 60);
        end
        tx_left--;
        gap = tx_eager ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_ch.valid     <= 1'b1;
        ev_ch.opcode    <= op;
        ev_ch.requester <= id;
        @(posedge clk);
        while (!(ev_ch.valid && ev_ch.ready)) @(posedge clk);
        @(negedge clk);
    endtask

    // release both kinds often enough to empty the queue and free every holder
    task automatic drain_lock();
        repeat (40) begin
            send_event(OP_REL_WR, rand_id());
            send_event(OP_REL_RD, rand_id());
        end
    endtask

    // result side
    initial begin
        int gap;
        int taken;
        taken = 0;
        res_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (rx_left == 0) begin
                rx_eager = ($urandom_range(0, 3) == 0);
                rx_left  = $urandom_range(10, 60);
            end
            rx_left--;
            // one long hold-off so the block backs up and stalls its input
            if (taken == HOLD_AT) gap = HOLD_LEN;
            else gap = rx_eager ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    // event side
    initial begin
        int sent;
        int burst;
        int kind_sel;
        ev_ch.valid     = 1'b0;
        ev_ch.opcode    = OP_ACQ_RD;
        ev_ch.requester = 8'h00;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // releases with nobody holding, then a writer taking the lock at once
        send_event(OP_REL_RD, 8'h00);
        send_event(OP_REL_WR, 8'hFF);
        send_event(OP_ACQ_WR, 8'hFF);
        // fill the queue behind the writer: three readers, a writer, and so on
        for (int i = 0; i < DEPTH; i++)
            send_event((i % 4 == 3) ? OP_ACQ_WR : OP_ACQ_RD, 8'(i * 17));
        // queue full, both kinds rejected
        send_event(OP_ACQ_WR, 8'h00);
        send_event(OP_ACQ_RD, 8'hFF);
        // one release wakes the three readers together, the third read release
        // lets the queued writer in
        send_event(OP_REL_WR, 8'h3C);
        repeat (3) send_event(OP_REL_RD, 8'hC3);
        drain_lock();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            kind_sel = $urandom_range(0, 3);
            burst = $urandom_range(5, 16);
            for (int i = 0; i < burst; i++) begin
                case (kind_sel)
                    0:       send_event(rand_acquire(), rand_id());
                    1:       send_event(rand_release(), rand_id());
                    default: send_event($urandom_range(0, 1) ? rand_acquire() : rand_release(),
                                        rand_id());
                endcase
            end
            sent += burst;
        end
        ev_ch.valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/frwl_pkg.sv
src/frwl_if.sv
src/frwl_ctrl.sv
src/frwl_dp.sv
src/fifo_fair_reader_writer_lock_top.sv
src/frwl_chk.sv
bench/frwl_lock_checker.sv
bench/tb_fifo_fair_reader_writer_lock_top.sv
